>>> hdl/pfc_pkg.sv
// Shared constants and types for the three-point parabola curvature block.
// Used by parabola_fit_curvature and its testbench; depends on nothing.
`timescale 1ns / 1ps

package pfc_pkg;

    // point and result format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;

    // coordinate differences and their magnitudes
    localparam int MAG_W   = COORD_W + 1;
    // slope magnitude: difference scaled by the fraction bits
    localparam int SLOPE_W = MAG_W + FRAC_BITS;
    // width of every clamped intermediate magnitude
    localparam int CAP_W   = 60;

    localparam logic [CAP_W-1:0]   ICAP     = {CAP_W{1'b1}};
    localparam logic [COORD_W-1:0] KCAP     = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] POS_MAX  = {1'b0, {(COORD_W-1){1'b1}}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

endpackage

>>> hdl/parabola_fit_curvature.sv
// Pipelined curvature of the parabola through three profile points.
// Depends on pfc_pkg (constants, status codes).
`timescale 1ns / 1ps

// One request (three points) is taken every clock cycle while the second output
// entry is empty, and one result leaves per cycle while i_out_ready is high. The
// pipeline depth is set by the chain of bit-per-stage units: the slope dividers
// (49 stages), the 2a divider (60 stages, run beside the product and
// square-root path) and the final divider (32 stages). The multipliers are
// split into partial products at bit 32 with a register after each. A two-entry
// output buffer decouples the sides: o_in_ready drops only when a result sits
// in the second entry, so input keeps flowing while one result waits.
module parabola_fit_curvature (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [pfc_pkg::COORD_W-1:0]   i_first_x,
    input  logic signed [pfc_pkg::COORD_W-1:0]   i_first_z,
    input  logic signed [pfc_pkg::COORD_W-1:0]   i_middle_x,
    input  logic signed [pfc_pkg::COORD_W-1:0]   i_middle_z,
    input  logic signed [pfc_pkg::COORD_W-1:0]   i_last_x,
    input  logic signed [pfc_pkg::COORD_W-1:0]   i_last_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [pfc_pkg::COORD_W-1:0]   o_curvature,
    output logic [1:0]                           o_status
);

    localparam int CW   = pfc_pkg::COORD_W;
    localparam int FB   = pfc_pkg::FRAC_BITS;
    localparam int MW   = pfc_pkg::MAG_W;
    localparam int SW   = pfc_pkg::SLOPE_W;
    localparam int QW   = pfc_pkg::CAP_W;
    // square-root input q << FB, root width
    localparam int XW   = QW + FB;
    localparam int RW   = XW / 2;
    localparam int L_SL = SW;
    localparam int L_A2 = QW;
    localparam int L_SQ = RW;
    localparam int L_K  = CW;
    // s path: 5 slope stages, 3 square stages, root, 3 product stages
    localparam int L_PD = L_A2 - (5 + 3 + L_SQ + 3);

    // divider lane, 33-bit divisor, slope quotient
    typedef struct packed {
        logic [MW-1:0] rem;
        logic [SW-1:0] acc;
        logic [MW-1:0] den;
    } t_dl;

    // divider lane, 33-bit divisor, 2a quotient
    typedef struct packed {
        logic [MW-1:0] rem;
        logic [QW-1:0] acc;
        logic [MW-1:0] den;
    } t_da;

    // divider lane, 60-bit divisor, final quotient
    typedef struct packed {
        logic [QW-1:0] rem;
        logic [CW-1:0] acc;
        logic [QW-1:0] den;
    } t_dk;

    typedef struct packed {
        logic sg1;
        logic sg2;
        logic tsb;
        logic deg;
        logic lvl;
        logic neg;
    } t_c1;

    typedef struct packed {
        logic deg;
        logic lvl;
        logic neg;
        logic sat;
    } t_cf;

    typedef struct packed {
        logic [MW-1:0] dz1;
        logic [MW-1:0] dz2;
        logic [MW-1:0] h1;
        logic [MW-1:0] h2;
        logic [MW-1:0] dd;
        t_c1           c;
    } t_sa;

    // ---------------------------------------------------------------- steps
    function automatic t_dl dl_step(t_dl x);
        logic [MW:0] rs;
        logic        ge;
        t_dl         y;
        rs    = {x.rem, x.acc[SW-1]};
        ge    = (rs >= {1'b0, x.den});
        y.den = x.den;
        y.rem = ge ? MW'(rs - {1'b0, x.den}) : rs[MW-1:0];
        y.acc = {x.acc[SW-2:0], ge};
        return y;
    endfunction

    function automatic t_da da_step(t_da x);
        logic [MW:0] rs;
        logic        ge;
        t_da         y;
        rs    = {x.rem, x.acc[QW-1]};
        ge    = (rs >= {1'b0, x.den});
        y.den = x.den;
        y.rem = ge ? MW'(rs - {1'b0, x.den}) : rs[MW-1:0];
        y.acc = {x.acc[QW-2:0], ge};
        return y;
    endfunction

    function automatic t_dk dk_step(t_dk x);
        logic [QW:0] rs;
        logic        ge;
        t_dk         y;
        rs    = {x.rem, x.acc[CW-1]};
        ge    = (rs >= {1'b0, x.den});
        y.den = x.den;
        y.rem = ge ? QW'(rs - {1'b0, x.den}) : rs[QW-1:0];
        y.acc = {x.acc[CW-2:0], ge};
        return y;
    endfunction

    function automatic logic [MW-1:0] mag33(logic signed [MW-1:0] v);
        return v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    // flags passed on with the saturation bit merged in
    function automatic t_cf cf_sat(t_cf c, logic s);
        t_cf y;
        y     = c;
        y.sat = c.sat | s;
        return y;
    endfunction

    // ------------------------------------------------------------ signals
    logic en;

    logic signed [MW-1:0] w_h1, w_h2, w_dd, w_dz1, w_dz2;
    logic signed [MW:0]   w_sum, w_twice;
    t_sa                  w_sa;

    logic r_a_v;
    t_sa  r_a;

    logic r_s1_v  [L_SL];
    t_dl  r_s1_l1 [L_SL];
    t_dl  r_s1_l2 [L_SL];
    t_dl  r_s1_lu [L_SL];
    t_c1  r_s1_c  [L_SL];

    logic signed [SW:0]   w_m1, w_m2;
    logic                 r_m1_v;
    logic signed [SW:0]   r_m1_m1;
    logic signed [SW+1:0] r_m1_dm;
    logic [SW-1:0]        r_m1_u;
    logic [MW-1:0]        r_m1_dd;
    t_c1                  r_m1_c;

    logic                 r_m2_v;
    logic signed [SW:0]   r_m2_m1;
    logic [SW:0]          r_m2_dmag;
    logic                 r_m2_tneg;
    logic [SW-1:0]        r_m2_u;
    logic [MW-1:0]        r_m2_dd;
    t_cf                  r_m2_cf;
    logic [SW+1:0]        w_dmag;

    t_da  r_a2_l   [L_A2];
    logic r_a2_ovf [L_A2];
    t_da  w_a2_seed;

    logic               r_t1_v;
    logic [63:0]        r_t1_pp0;
    logic [48:0]        r_t1_pp1;
    logic [49:0]        r_t1_pp2;
    logic [34:0]        r_t1_pp3;
    logic signed [SW:0] r_t1_m1;
    logic               r_t1_tneg;
    t_cf                r_t1_cf;

    logic               r_t2_v;
    logic [98:0]        r_t2_prod;
    logic signed [SW:0] r_t2_m1;
    logic               r_t2_tneg;
    t_cf                r_t2_cf;

    logic               r_t3_v;
    logic [QW-1:0]      r_t3_t;
    logic signed [SW:0] r_t3_m1;
    logic               r_t3_tneg;
    t_cf                r_t3_cf;

    logic signed [QW+1:0] w_ts;
    logic                 r_t4_v;
    logic signed [QW+1:0] r_t4_s;
    t_cf                  r_t4_cf;

    logic [QW+1:0] w_smag;
    logic          r_t5_v;
    logic [QW-1:0] r_t5_sm;
    t_cf           r_t5_cf;

    logic        r_q1_v;
    logic [63:0] r_q1_pp0;
    logic [59:0] r_q1_pp1;
    logic [55:0] r_q1_pp3;
    t_cf         r_q1_cf;

    logic         r_q2_v;
    logic [119:0] r_q2_prod;
    t_cf          r_q2_cf;

    logic [QW:0]   w_qs;
    logic          r_q3_v;
    logic [QW-1:0] r_q3_q;
    t_cf           r_q3_cf;

    logic          r_sq_v    [L_SQ];
    logic [RW+1:0] r_sq_rem  [L_SQ];
    logic [RW-1:0] r_sq_root [L_SQ];
    logic [XW-1:0] r_sq_x    [L_SQ];
    logic [QW-1:0] r_sq_q    [L_SQ];
    t_cf           r_sq_cf   [L_SQ];

    logic        r_p1_v;
    logic [63:0] r_p1_pp0;
    logic [37:0] r_p1_pp1;
    logic [59:0] r_p1_pp2;
    logic [33:0] r_p1_pp3;
    t_cf         r_p1_cf;

    logic        r_p2_v;
    logic [97:0] r_p2_prod;
    t_cf         r_p2_cf;

    logic          r_p3_v;
    logic [QW-1:0] r_p3_p;
    t_cf           r_p3_cf;

    logic          r_pd_v  [L_PD];
    logic [QW-1:0] r_pd_p  [L_PD];
    t_cf           r_pd_cf [L_PD];

    logic          r_j_v;
    logic [QW-1:0] r_j_a2;
    logic [QW-1:0] r_j_p;
    t_cf           r_j_cf;
    t_dk           w_k_seed;

    logic r_k_v   [L_K];
    t_dk  r_k_l   [L_K];
    logic r_k_ovf [L_K];
    t_cf  r_k_cf  [L_K];

    logic [CW-1:0]      f_kq, f_k;
    logic               f_big, f_clip;
    t_cf                f_cf;
    logic signed [CW-1:0] f_curv;
    pfc_pkg::t_status   f_st;

    logic                 push, pop;
    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_curv;
    pfc_pkg::t_status     r_out_status;
    logic                 r_skid_v;
    logic signed [CW-1:0] r_skid_curv;
    pfc_pkg::t_status     r_skid_status;

    // pipeline moves unless the second output entry is occupied
    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // ------------------------------------------------- input differences
    always_comb begin
        w_h1    = MW'(i_middle_x) - MW'(i_first_x);
        w_h2    = MW'(i_last_x) - MW'(i_middle_x);
        w_dd    = MW'(i_last_x) - MW'(i_first_x);
        w_dz1   = MW'(i_middle_z) - MW'(i_first_z);
        w_dz2   = MW'(i_last_z) - MW'(i_middle_z);
        w_sum   = (MW+1)'(i_first_z) + (MW+1)'(i_last_z);
        w_twice = (MW+1)'(i_middle_z) <<< 1;
        w_sa.dz1   = mag33(w_dz1);
        w_sa.dz2   = mag33(w_dz2);
        w_sa.h1    = mag33(w_h1);
        w_sa.h2    = mag33(w_h2);
        w_sa.dd    = mag33(w_dd);
        w_sa.c.sg1 = w_dz1[MW-1] ^ w_h1[MW-1];
        w_sa.c.sg2 = w_dz2[MW-1] ^ w_h2[MW-1];
        w_sa.c.tsb = w_h1[MW-1] ^ w_dd[MW-1];
        w_sa.c.deg = (w_h1 == '0) || (w_h2 == '0) || (w_dd == '0);
        w_sa.c.lvl = (w_sum == w_twice);
        w_sa.c.neg = (w_sum < w_twice);
    end

    // ------------------------------------------------ middle combinational
    always_comb begin
        w_m1 = r_s1_c[L_SL-1].sg1 ? -$signed({1'b0, r_s1_l1[L_SL-1].acc})
                                  :  $signed({1'b0, r_s1_l1[L_SL-1].acc});
        w_m2 = r_s1_c[L_SL-1].sg2 ? -$signed({1'b0, r_s1_l2[L_SL-1].acc})
                                  :  $signed({1'b0, r_s1_l2[L_SL-1].acc});
        w_dmag = r_m1_dm[SW+1] ? (SW+2)'(-r_m1_dm) : (SW+2)'(r_m1_dm);

        // 2a divider: quotient bits at and above QW mean overflow
        w_a2_seed.rem = MW'(r_m2_dmag[SW:QW-FB-1]);
        w_a2_seed.acc = {r_m2_dmag[QW-FB-2:0], {(FB+1){1'b0}}};
        w_a2_seed.den = r_m2_dd;

        w_ts   = $signed({2'b00, r_t3_t});
        w_smag = r_t4_s[QW+1] ? (QW+2)'(-r_t4_s) : (QW+2)'(r_t4_s);
        w_qs   = (QW+1)'(r_q2_prod[XW-1:FB]) + ((QW+1)'(1) << FB);

        // final divider starts from the integer part of 4*|2a| / p
        w_k_seed.rem = QW'(r_j_a2[QW-1:FB-2]);
        w_k_seed.acc = {r_j_a2[FB-3:0], {(CW-FB+2){1'b0}}};
        w_k_seed.den = r_j_p;
    end

    // ------------------------------------------------------ valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
            r_t5_v <= 1'b0;
            r_q1_v <= 1'b0;
            r_q2_v <= 1'b0;
            r_q3_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_j_v  <= 1'b0;
            for (int i = 0; i < L_SL; i++) r_s1_v[i] <= 1'b0;
            for (int i = 0; i < L_SQ; i++) r_sq_v[i] <= 1'b0;
            for (int i = 0; i < L_PD; i++) r_pd_v[i] <= 1'b0;
            for (int i = 0; i < L_K; i++)  r_k_v[i]  <= 1'b0;
        end else if (en) begin
            r_a_v     <= i_in_valid;
            r_s1_v[0] <= r_a_v;
            for (int i = 1; i < L_SL; i++) r_s1_v[i] <= r_s1_v[i-1];
            r_m1_v    <= r_s1_v[L_SL-1];
            r_m2_v    <= r_m1_v;
            r_t1_v    <= r_m2_v;
            r_t2_v    <= r_t1_v;
            r_t3_v    <= r_t2_v;
            r_t4_v    <= r_t3_v;
            r_t5_v    <= r_t4_v;
            r_q1_v    <= r_t5_v;
            r_q2_v    <= r_q1_v;
            r_q3_v    <= r_q2_v;
            r_sq_v[0] <= r_q3_v;
            for (int i = 1; i < L_SQ; i++) r_sq_v[i] <= r_sq_v[i-1];
            r_p1_v    <= r_sq_v[L_SQ-1];
            r_p2_v    <= r_p1_v;
            r_p3_v    <= r_p2_v;
            r_pd_v[0] <= r_p3_v;
            for (int i = 1; i < L_PD; i++) r_pd_v[i] <= r_pd_v[i-1];
            r_j_v     <= r_pd_v[L_PD-1];
            r_k_v[0]  <= r_j_v;
            for (int i = 1; i < L_K; i++) r_k_v[i] <= r_k_v[i-1];
        end
    end

    // ------------------------------------------------ slopes and h1/D
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= w_sa;
            r_s1_l1[0] <= dl_step('{rem: '0, acc: {r_a.dz1, {FB{1'b0}}}, den: r_a.h1});
            r_s1_l2[0] <= dl_step('{rem: '0, acc: {r_a.dz2, {FB{1'b0}}}, den: r_a.h2});
            r_s1_lu[0] <= dl_step('{rem: '0, acc: {r_a.h1, {FB{1'b0}}}, den: r_a.dd});
            r_s1_c[0]  <= r_a.c;
            for (int i = 1; i < L_SL; i++) begin
                r_s1_l1[i] <= dl_step(r_s1_l1[i-1]);
                r_s1_l2[i] <= dl_step(r_s1_l2[i-1]);
                r_s1_lu[i] <= dl_step(r_s1_lu[i-1]);
                r_s1_c[i]  <= r_s1_c[i-1];
            end
        end
    end

    // ------------------------------------- slope difference, then magnitude
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_m1 <= w_m1;
            r_m1_dm <= (SW+2)'(w_m2) - (SW+2)'(w_m1);
            r_m1_u  <= r_s1_lu[L_SL-1].acc;
            r_m1_dd <= r_s1_lu[L_SL-1].den;
            r_m1_c  <= r_s1_c[L_SL-1];

            r_m2_m1     <= r_m1_m1;
            r_m2_dmag   <= w_dmag[SW:0];
            r_m2_tneg   <= r_m1_dm[SW+1] ^ r_m1_c.tsb;
            r_m2_u      <= r_m1_u;
            r_m2_dd     <= r_m1_dd;
            r_m2_cf.deg <= r_m1_c.deg;
            r_m2_cf.lvl <= r_m1_c.lvl;
            r_m2_cf.neg <= r_m1_c.neg;
            r_m2_cf.sat <= 1'b0;
        end
    end

    // ---------------------------------------------------- 2a divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a2_l[0]   <= da_step(w_a2_seed);
            r_a2_ovf[0] <= (w_a2_seed.rem >= r_m2_dd);
            for (int i = 1; i < L_A2; i++) begin
                r_a2_l[i]   <= da_step(r_a2_l[i-1]);
                r_a2_ovf[i] <= r_a2_ovf[i-1];
            end
        end
    end

    // ------------------------------------- slope at the middle point, s^2
    always_ff @(posedge i_clk) begin
        if (en) begin
            // |dm| * u in partial products
            r_t1_pp0  <= 64'(r_m2_dmag[31:0]) * 64'(r_m2_u[31:0]);
            r_t1_pp1  <= 49'(r_m2_dmag[31:0]) * 49'(r_m2_u[SW-1:32]);
            r_t1_pp2  <= 50'(r_m2_dmag[SW:32]) * 50'(r_m2_u[31:0]);
            r_t1_pp3  <= 35'(r_m2_dmag[SW:32]) * 35'(r_m2_u[SW-1:32]);
            r_t1_m1   <= r_m2_m1;
            r_t1_tneg <= r_m2_tneg;
            r_t1_cf   <= r_m2_cf;

            r_t2_prod <= 99'(r_t1_pp0) + (99'(r_t1_pp1) << 32)
                       + (99'(r_t1_pp2) << 32) + (99'(r_t1_pp3) << 64);
            r_t2_m1   <= r_t1_m1;
            r_t2_tneg <= r_t1_tneg;
            r_t2_cf   <= r_t1_cf;

            r_t3_t      <= (|r_t2_prod[98:XW]) ? pfc_pkg::ICAP : r_t2_prod[XW-1:FB];
            r_t3_m1     <= r_t2_m1;
            r_t3_tneg   <= r_t2_tneg;
            r_t3_cf     <= cf_sat(r_t2_cf, |r_t2_prod[98:XW]);

            r_t4_s  <= (QW+2)'(r_t3_m1) + (r_t3_tneg ? -w_ts : w_ts);
            r_t4_cf <= r_t3_cf;

            r_t5_sm     <= (|w_smag[QW+1:QW]) ? pfc_pkg::ICAP : w_smag[QW-1:0];
            r_t5_cf     <= cf_sat(r_t4_cf, |w_smag[QW+1:QW]);

            // sm * sm: cross term counted twice
            r_q1_pp0 <= 64'(r_t5_sm[31:0]) * 64'(r_t5_sm[31:0]);
            r_q1_pp1 <= 60'(r_t5_sm[31:0]) * 60'(r_t5_sm[QW-1:32]);
            r_q1_pp3 <= 56'(r_t5_sm[QW-1:32]) * 56'(r_t5_sm[QW-1:32]);
            r_q1_cf  <= r_t5_cf;

            r_q2_prod <= 120'(r_q1_pp0) + (120'(r_q1_pp1) << 33) + (120'(r_q1_pp3) << 64);
            r_q2_cf   <= r_q1_cf;

            // q = 1 + s^2, clamped
            if ((|r_q2_prod[119:XW]) || w_qs[QW]) begin
                r_q3_q <= pfc_pkg::ICAP;
            end else begin
                r_q3_q <= w_qs[QW-1:0];
            end
            r_q3_cf     <= cf_sat(r_q2_cf, (|r_q2_prod[119:XW]) | w_qs[QW]);
        end
    end

    // --------------------------------------------- square root, bit a stage
    always_ff @(posedge i_clk) begin
        logic [XW-1:0] x;
        logic [RW+1:0] rem;
        logic [RW-1:0] root;
        logic [RW+3:0] rs;
        logic [RW+1:0] trial;
        logic          ge;
        if (en) begin
            for (int i = 0; i < L_SQ; i++) begin
                if (i == 0) begin
                    x    = {r_q3_q, {FB{1'b0}}};
                    rem  = '0;
                    root = '0;
                end else begin
                    x    = r_sq_x[i-1];
                    rem  = r_sq_rem[i-1];
                    root = r_sq_root[i-1];
                end
                rs    = {rem, x[XW-1:XW-2]};
                trial = {root, 2'b01};
                ge    = (rs >= (RW+4)'(trial));
                r_sq_rem[i]  <= ge ? (RW+2)'(rs - (RW+4)'(trial)) : rs[RW+1:0];
                r_sq_root[i] <= {root[RW-2:0], ge};
                r_sq_x[i]    <= {x[XW-3:0], 2'b00};
            end
            r_sq_q[0]  <= r_q3_q;
            r_sq_cf[0] <= r_q3_cf;
            for (int i = 1; i < L_SQ; i++) begin
                r_sq_q[i]  <= r_sq_q[i-1];
                r_sq_cf[i] <= r_sq_cf[i-1];
            end
        end
    end

    // ------------------------------------------- p = q * r, align with 2a
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_pp0 <= 64'(r_sq_q[L_SQ-1][31:0]) * 64'(r_sq_root[L_SQ-1][31:0]);
            r_p1_pp1 <= 38'(r_sq_q[L_SQ-1][31:0]) * 38'(r_sq_root[L_SQ-1][RW-1:32]);
            r_p1_pp2 <= 60'(r_sq_q[L_SQ-1][QW-1:32]) * 60'(r_sq_root[L_SQ-1][31:0]);
            r_p1_pp3 <= 34'(r_sq_q[L_SQ-1][QW-1:32]) * 34'(r_sq_root[L_SQ-1][RW-1:32]);
            r_p1_cf  <= r_sq_cf[L_SQ-1];

            r_p2_prod <= 98'(r_p1_pp0) + (98'(r_p1_pp1) << 32)
                       + (98'(r_p1_pp2) << 32) + (98'(r_p1_pp3) << 64);
            r_p2_cf   <= r_p1_cf;

            r_p3_p      <= (|r_p2_prod[97:XW]) ? pfc_pkg::ICAP : r_p2_prod[XW-1:FB];
            r_p3_cf     <= cf_sat(r_p2_cf, |r_p2_prod[97:XW]);

            r_pd_p[0]  <= r_p3_p;
            r_pd_cf[0] <= r_p3_cf;
            for (int i = 1; i < L_PD; i++) begin
                r_pd_p[i]  <= r_pd_p[i-1];
                r_pd_cf[i] <= r_pd_cf[i-1];
            end

            // join: clamped 2a meets p
            r_j_a2     <= r_a2_ovf[L_A2-1] ? pfc_pkg::ICAP : r_a2_l[L_A2-1].acc;
            r_j_p      <= r_pd_p[L_PD-1];
            r_j_cf     <= cf_sat(r_pd_cf[L_PD-1], r_a2_ovf[L_A2-1]);
        end
    end

    // ------------------------------------------------- final divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_l[0]   <= dk_step(w_k_seed);
            r_k_ovf[0] <= (w_k_seed.rem >= r_j_p);
            r_k_cf[0]  <= r_j_cf;
            for (int i = 1; i < L_K; i++) begin
                r_k_l[i]   <= dk_step(r_k_l[i-1]);
                r_k_ovf[i] <= r_k_ovf[i-1];
                r_k_cf[i]  <= r_k_cf[i-1];
            end
        end
    end

    // ----------------------------------------- saturation, sign, status
    always_comb begin
        f_cf   = r_k_cf[L_K-1];
        f_kq   = r_k_l[L_K-1].acc;
        f_big  = r_k_ovf[L_K-1] || (f_kq > pfc_pkg::KCAP);
        f_k    = f_big ? pfc_pkg::KCAP : f_kq;
        f_clip = !f_cf.neg && f_k[CW-1];
        if (f_clip) begin
            f_k = pfc_pkg::POS_MAX;
        end
        f_curv = f_cf.neg ? $signed(-f_k) : $signed(f_k);
        if (f_cf.deg) begin
            f_curv = '0;
            f_st   = pfc_pkg::ST_DEGEN;
        end else if (f_cf.lvl) begin
            f_curv = '0;
            f_st   = pfc_pkg::ST_OK;
        end else if (f_cf.sat || f_big || f_clip) begin
            f_st   = pfc_pkg::ST_SAT;
        end else begin
            f_st   = pfc_pkg::ST_OK;
        end
    end

    // ------------------------------------------ two-entry output buffer
    assign push = en && r_k_v[L_K-1];
    assign pop  = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_v    <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_out_curv   <= r_skid_curv;
                r_out_status <= r_skid_status;
                r_skid_v     <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_curv   <= f_curv;
                r_out_status <= f_st;
                r_out_valid  <= 1'b1;
            end else begin
                r_skid_curv   <= f_curv;
                r_skid_status <= f_st;
                r_skid_v      <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_curvature = r_out_curv;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    // second entry is only ever filled behind a waiting first entry
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_valid)
        else $error("output buffer second entry holds data with first empty");

    // a held second entry is kept until the first one is taken
    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !(r_out_valid && i_out_ready)) |=> r_skid_v)
        else $error("output buffer dropped a waiting result");

    // degenerate abscissae always report a zero curvature
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == pfc_pkg::ST_DEGEN)) |-> (r_out_curv == '0))
        else $error("degenerate status with nonzero curvature");

    // an accepted request enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_a_v)
        else $error("accepted request missing from first stage");
`endif

endmodule

>>> test/tb_parabola_fit_curvature.sv
// Testbench for parabola_fit_curvature: fed point triples, checks curvature and status.
// Depends on pfc_pkg and the parabola_fit_curvature RTL; the golden values come from
// a bit-exact fixed-point curvature calculator kept inside this file.
`timescale 1ns / 1ps

module tb_parabola_fit_curvature;

    localparam int  CW             = pfc_pkg::COORD_W;
    localparam int  FB             = pfc_pkg::FRAC_BITS;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  DRAIN_CYCLES   = 300;
    localparam int  RANDOM_TRIPLES = 1250;
    localparam logic [63:0] CAP64  = 64'(pfc_pkg::ICAP);
    localparam logic [63:0] KLIM   = 64'h8000_0000;

    typedef struct packed {
        logic signed [CW-1:0] fx, fz, mx, mz, lx, lz;
    } t_triple;

    typedef struct packed {
        logic signed [CW-1:0] curv;
        pfc_pkg::t_status     stat;
    } t_curv_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_first_x, i_first_z, i_middle_x;
    logic signed [CW-1:0] i_middle_z, i_last_x, i_last_z;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [CW-1:0] o_curvature;
    logic [1:0]           o_status;

    t_triple      pending_triples[$];
    t_curv_result expected_curv[$];
    bit           clamp_seen;
    bit           failed;
    bit           req_taken;
    bit           res_taken;
    bit           idle_enable;
    int           send_gap;
    int           recv_stall;
    int           quiet_cycles;
    int           sent_count;

    parabola_fit_curvature u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_first_x   (i_first_x),
        .i_first_z   (i_first_z),
        .i_middle_x  (i_middle_x),
        .i_middle_z  (i_middle_z),
        .i_last_x    (i_last_x),
        .i_last_z    (i_last_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_curvature (o_curvature),
        .o_status    (o_status)
    );

    // clock, 4 ns period
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- fixed-point curvature calculator ----------------

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // min(floor(n * 2^fb / d), cap)
    function automatic logic [63:0] frac_div(input logic [63:0] n, input logic [63:0] d,
                                             input int fb, input logic [63:0] cap);
        logic [127:0] quo;
        quo = ({64'd0, n} << fb) / {64'd0, d};
        if (quo > {64'd0, cap}) begin
            clamp_seen = 1'b1;
            return cap;
        end
        return quo[63:0];
    endfunction

    // min(floor(a * b / 2^FB), ICAP)
    function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, b}) >> FB;
        if (prod > {64'd0, CAP64}) begin
            clamp_seen = 1'b1;
            return CAP64;
        end
        return prod[63:0];
    endfunction

    // floor(sqrt(q * 2^FB))
    function automatic logic [63:0] frac_sqrt(input logic [63:0] q);
        logic [127:0] x;
        logic [127:0] root;
        logic [127:0] trial;
        x    = {64'd0, q} << FB;
        root = '0;
        for (int i = 40; i >= 0; i--) begin
            trial = root | (128'd1 << i);
            if (trial * trial <= x) root = trial;
        end
        return root[63:0];
    endfunction

    function automatic longint signed_slope(input longint dz, input longint dx);
        longint m;
        m = longint'(frac_div(abs64(dz), abs64(dx), FB, CAP64));
        return ((dz < 0) != (dx < 0)) ? -m : m;
    endfunction

    function automatic t_curv_result predict_curvature(input t_triple p);
        t_curv_result res;
        longint ax, az, bx, bz, cx, cz, h1, h2, dd, m1, m2, dm, s;
        logic [63:0] a2, u, t, sm, q, r, pw, k;
        bit neg, tneg;
        ax = p.fx; az = p.fz; bx = p.mx; bz = p.mz; cx = p.lx; cz = p.lz;
        h1 = bx - ax; h2 = cx - bx; dd = cx - ax;
        clamp_seen = 1'b0;
        res.curv = '0;
        res.stat = pfc_pkg::ST_OK;
        // coincident abscissae: no parabola
        if (h1 == 0 || h2 == 0 || dd == 0) begin
            res.stat = pfc_pkg::ST_DEGEN;
            return res;
        end
        // outer mean equals middle height
        if (az + cz == 2 * bz) return res;
        neg  = (az + cz) < 2 * bz;
        m1   = signed_slope(bz - az, h1);
        m2   = signed_slope(cz - bz, h2);
        dm   = m2 - m1;
        a2   = frac_div(abs64(dm), abs64(dd), FB + 1, CAP64);
        u    = frac_div(abs64(h1), abs64(dd), FB, CAP64);
        t    = frac_mul(abs64(dm), u);
        tneg = ((dm < 0) != (h1 < 0)) != (dd < 0);
        s    = m1 + (tneg ? -longint'(t) : longint'(t));
        sm   = abs64(s);
        if (sm > CAP64) begin
            sm = CAP64;
            clamp_seen = 1'b1;
        end
        q = (64'd1 << FB) + frac_mul(sm, sm);
        if (q > CAP64) begin
            q = CAP64;
            clamp_seen = 1'b1;
        end
        r  = frac_sqrt(q);
        pw = frac_mul(q, r);
        k  = frac_div(a2 << 2, pw, FB, KLIM);
        if (!neg && k > KLIM - 1) begin
            k = KLIM - 1;
            clamp_seen = 1'b1;
        end
        res.curv = neg ? CW'(-k) : CW'(k);
        res.stat = clamp_seen ? pfc_pkg::ST_SAT : pfc_pkg::ST_OK;
        return res;
    endfunction

    // ---------------- stimulus generation ----------------

    function automatic t_triple make_triple(input int fx, input int fz, input int mx,
                                            input int mz, input int lx, input int lz);
        t_triple p;
        p.fx = fx; p.fz = fz; p.mx = mx; p.mz = mz; p.lx = lx; p.lz = lz;
        return p;
    endfunction

    // sampled parabola: ordered or shuffled abscissae, moderate heights
    function automatic t_triple random_parabola();
        int base, h1, h2, zr;
        base = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        h1   = int'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 32'h0004_0000 : 32'h0000_0400));
        h2   = int'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 32'h0004_0000 : 32'h0000_0400));
        if ($urandom_range(0, 3) == 0) h1 = -h1;
        if ($urandom_range(0, 3) == 0) h2 = -h2;
        zr   = 1 << $urandom_range(4, 26);
        return make_triple(base - h1, int'($urandom_range(0, zr)) - zr / 2,
                           base,      int'($urandom_range(0, zr)) - zr / 2,
                           base + h2, int'($urandom_range(0, zr)) - zr / 2);
    endfunction

    function automatic t_triple random_triple();
        t_triple p;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            p = random_parabola();
        end else if (sel < 85) begin
            p = make_triple($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (sel < 93) begin
            // coincident abscissae
            p = random_parabola();
            case ($urandom_range(0, 2))
                0: p.mx = p.fx;
                1: p.lx = p.mx;
                default: p.lx = p.fx;
            endcase
        end else begin
            // level middle
            p = random_parabola();
            p.lz = 2 * p.mz - p.fz;
        end
        return p;
    endfunction

    // ---------------- driver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            // request side
            if (i_in_valid && !req_taken) begin
                // hold until accepted
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_triples.size() > 0) begin
                t_triple p;
                p = pending_triples.pop_front();
                i_first_x  <= p.fx; i_first_z  <= p.fz;
                i_middle_x <= p.mx; i_middle_z <= p.mz;
                i_last_x   <= p.lx; i_last_z   <= p.lz;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
            req_taken = 1'b0;
            // result side
            if (res_taken) begin
                recv_stall = idle_enable ? $urandom_range(0, 4) : 0;
                res_taken  = 1'b0;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------- monitor and watchdog ----------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_in_valid && o_in_ready) begin
                req_taken = 1'b1;
                quiet_cycles = 0;
                sent_count++;
                expected_curv.push_back(predict_curvature(
                    make_triple(i_first_x, i_first_z, i_middle_x,
                                i_middle_z, i_last_x, i_last_z)));
                send_gap = idle_enable ? $urandom_range(0, 4) : 0;
                if (sent_count % 97 == 0) idle_enable = $urandom_range(0, 2) != 0;
            end
            if (o_out_valid && i_out_ready) begin
                t_curv_result want;
                res_taken = 1'b1;
                quiet_cycles = 0;
                if (expected_curv.size() == 0) begin
                    $error("unexpected result: curvature %0d status %0d", o_curvature, o_status);
                    failed = 1'b1;
                end else begin
                    want = expected_curv.pop_front();
                    if (o_curvature !== want.curv) begin
                        $error("curvature: expected %0d, got %0d", want.curv, o_curvature);
                        failed = 1'b1;
                    end
                    if (o_status !== want.stat) begin
                        $error("status: expected %0d, got %0d", want.stat, o_status);
                        failed = 1'b1;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_parabola_fit_curvature: FAIL");
                $finish;
            end
        end
    end

    // ---------------- test sequence ----------------

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_first_x   = '0; i_first_z  = '0; i_middle_x = '0;
        i_middle_z  = '0; i_last_x   = '0; i_last_z   = '0;
        failed      = 1'b0;
        req_taken   = 1'b0;
        res_taken   = 1'b0;
        idle_enable = 1'b1;
        send_gap    = 0;
        recv_stall  = 0;
        quiet_cycles = 0;
        sent_count  = 0;

        // directed: plain parabolas, both curvature signs
        pending_triples.push_back(make_triple(-32'sh10000, 32'sh10000, 0, 0,
                                              32'sh10000, 32'sh10000));
        pending_triples.push_back(make_triple(-32'sh10000, -32'sh10000, 0, 0,
                                              32'sh10000, -32'sh10000));
        pending_triples.push_back(make_triple(0, 0, 32'sh30000, 32'sh8000,
                                              32'sh50000, -32'sh20000));
        // descending abscissae
        pending_triples.push_back(make_triple(32'sh50000, 5, 32'sh20000, 32'sh7000,
                                              -32'sh1000, 3));
        // coincident abscissae, each pair
        pending_triples.push_back(make_triple(7, 1, 7, 2, 9, 3));
        pending_triples.push_back(make_triple(7, 1, 9, 2, 9, 3));
        pending_triples.push_back(make_triple(7, 1, 9, 2, 7, 3));
        pending_triples.push_back(make_triple(0, 0, 0, 0, 0, 0));
        // level middle, straight line and flat
        pending_triples.push_back(make_triple(0, 0, 32'sh10000, 32'sh10000,
                                              32'sh20000, 32'sh20000));
        pending_triples.push_back(make_triple(1, 5, 2, 5, 3, 5));
        // extremes of the fields: steep, sharp, saturating
        pending_triples.push_back(make_triple(0, 32'sh7FFFFFFF, 1, 32'sh80000000,
                                              2, 32'sh7FFFFFFF));
        pending_triples.push_back(make_triple(0, 32'sh80000000, 1, 32'sh7FFFFFFF,
                                              2, 32'sh80000000));
        pending_triples.push_back(make_triple(32'sh80000000, 0, 0, 1,
                                              32'sh7FFFFFFF, 0));
        pending_triples.push_back(make_triple(32'sh80000000, 32'sh80000000, 0,
                                              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000));
        pending_triples.push_back(make_triple(32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                              32'sh80000000, 32'sh80000000,
                                              32'sh7FFFFFFE, 32'sh7FFFFFFF));
        pending_triples.push_back(make_triple(-1, 0, 0, 1, 1, 0));
        pending_triples.push_back(make_triple(-1, 0, 0, -1, 1, 0));
        pending_triples.push_back(make_triple(0, 0, 1, 1, 32'sh7FFFFFFF, 0));
        // large slope with gentle bend
        pending_triples.push_back(make_triple(0, 0, 32'sh100, 32'sh40000000,
                                              32'sh200, 32'sh7FFFFF00));
        for (int n = 0; n < RANDOM_TRIPLES; n++) pending_triples.push_back(random_triple());

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_triples.size() == 0 && !i_in_valid && expected_curv.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("tb_parabola_fit_curvature: PASS");
        end else begin
            $display("tb_parabola_fit_curvature: FAIL");
        end
        $finish;
    end

endmodule
